/* sv/peak_interval_overlap_finder_macros.svh */
// Assertion macros for the peak interval overlap finder
`ifndef PEAK_INTERVAL_OVERLAP_FINDER_MACROS_SVH
`define PEAK_INTERVAL_OVERLAP_FINDER_MACROS_SVH

// Implication or sequence property, checked outside reset.
`define PIO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Plain invariant that holds on every edge outside reset.
`define PIO_ASSERT_INV(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

`endif

/* sv/pio_pkg.sv */
// Types and constants shared by the peak interval overlap finder modules
package pio_pkg;

  localparam int unsigned MAX_INTERVALS_DEF = 16;
  localparam int unsigned TIME_W            = 12;
  localparam int unsigned PEAK_W            = 5;

  localparam logic [TIME_W-1:0] END_CAP = TIME_W'(2400);

  localparam logic KIND_PEAK   = 1'b0;
  localparam logic KIND_PERIOD = 1'b1;

  typedef enum logic {
    CMP_COUNT = 1'b0,  // arrival inside the stored interval
    CMP_END   = 1'b1   // departure after t and below the running end
  } cmp_mode_e;

  typedef struct packed {
    logic [TIME_W-1:0] arrive_time;
    logic [TIME_W-1:0] depart_time;
    logic              last_flight;
  } in_word_t;

  typedef struct packed {
    logic              kind;
    logic [PEAK_W-1:0] peak_count;
    logic [TIME_W-1:0] period_start;
    logic [TIME_W-1:0] period_end;
    logic              overflow;
    logic              last_result;
  } res_word_t;

  typedef struct packed {
    logic [TIME_W-1:0] arrive;
    logic [TIME_W-1:0] depart;
  } entry_t;

  typedef struct packed {
    cmp_mode_e         mode;
    logic [TIME_W-1:0] t;
    entry_t            ent;
    logic [TIME_W-1:0] cur_end;
  } cmp_req_t;

  typedef struct packed {
    logic flag;
  } cmp_rsp_t;

endpackage

/* sv/pio_store.sv */
// Interval store: one write port, two registered read ports
module pio_store import pio_pkg::*; #(
  parameter int unsigned DEPTH = MAX_INTERVALS_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic [AW-1:0] addr_a_i,
  input  logic [AW-1:0] addr_b_i,
  output entry_t        rdata_a_o,
  output entry_t        rdata_b_o
);

  entry_t mem [DEPTH];
  entry_t rd_a_q;
  entry_t rd_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_a_q <= mem[addr_a_i];
    rd_b_q <= mem[addr_b_i];
  end

  assign rdata_a_o = rd_a_q;
  assign rdata_b_o = rd_b_q;

endmodule

/* sv/pio_cmp.sv */
// Shared compare unit: interval containment or earliest-later-departure test
module pio_cmp import pio_pkg::*; (
  input  cmp_req_t req_i,
  output cmp_rsp_t rsp_o
);

  logic lo_ok;
  logic hi_ok;

  always_comb begin
    unique case (req_i.mode)
      CMP_COUNT: begin
        lo_ok = (req_i.ent.arrive <= req_i.t);
        hi_ok = (req_i.t <= req_i.ent.depart);
      end
      CMP_END: begin
        lo_ok = (req_i.ent.depart > req_i.t);
        hi_ok = (req_i.ent.depart < req_i.cur_end);
      end
      default: begin
        lo_ok = 1'b0;
        hi_ok = 1'b0;
      end
    endcase
    rsp_o.flag = lo_ok & hi_ok;
  end

endmodule

/* sv/peak_interval_overlap_finder.sv */
// Top level: loads intervals, finds peak overlap and busiest periods, emits results
// Load: one word per cycle; busy stays low until a word with last_flight is taken.
// Then busy while it counts the overlaps of every stored arrival, emits the peak word, then checks
//   each arrival up to the last busiest one and scans all entries for each busiest period's end.
// Each result word strobes one cycle, no stall; the peak word follows the whole count pass.
// Reset (rst_ni low, async) empties the run; store contents stay undefined until loaded.
`include "peak_interval_overlap_finder_macros.svh"

module peak_interval_overlap_finder import pio_pkg::*; #(
  parameter int unsigned MAX_INTERVALS = MAX_INTERVALS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  in_word_t  item_i,
  output logic      result_strobe_o,
  output res_word_t result_o
);

  // counters reach MAX_INTERVALS itself; addresses only index the store
  localparam int unsigned CW = $clog2(MAX_INTERVALS + 1);
  localparam int unsigned AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam logic [CW-1:0] FULL = CW'(MAX_INTERVALS);

  typedef enum logic [2:0] {
    ST_IDLE,   // loading words
    ST_SCAN,   // walk all stored intervals through the compare unit
    ST_PEAK,   // emit the peak result
    ST_PWAIT,  // count memory read in flight
    ST_PCHK    // decide whether arrival i is a busiest-period start
  } state_e;

  state_e         state_q;
  cmp_mode_e      mode_q;
  logic [CW-1:0]  n_q;        // stored intervals
  logic           ovf_q;
  logic [CW-1:0]  best_q;     // running peak
  logic [AW-1:0]  last_idx_q; // last arrival whose count equals the peak
  logic [AW-1:0]  i_q;        // outer index (arrival under test)
  logic [CW-1:0]  j_q;        // inner issue index
  logic           rv_q;       // store read data valid this cycle
  logic           rl_q;       // ... and it is the last entry of the scan
  logic [CW-1:0]  acc_q;
  logic [TIME_W-1:0] end_q;
  logic           strobe_q;
  res_word_t      res_q;

  logic [CW-1:0]  cnt_mem [MAX_INTERVALS];
  logic [CW-1:0]  cnt_rd_q;

  logic           accept;
  logic           store_we;
  entry_t         wr_ent;
  entry_t         rd_a;
  entry_t         rd_b;
  cmp_req_t       cmp_req;
  cmp_rsp_t       cmp_rsp;
  logic           issue;
  logic [CW-1:0]  cnt_fin;
  logic [TIME_W-1:0] end_fin;
  logic           count_done;
  logic           i_is_last;

  assign busy     = (state_q != ST_IDLE);
  assign accept   = start & ~busy;
  assign store_we = accept & (n_q != FULL);
  assign wr_ent.arrive = item_i.arrive_time;
  assign wr_ent.depart = item_i.depart_time;

  pio_store #(
    .DEPTH (MAX_INTERVALS),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (store_we),
    .waddr_i   (n_q[AW-1:0]),
    .wdata_i   (wr_ent),
    .addr_a_i  (i_q),
    .addr_b_i  (j_q[AW-1:0]),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  // port A holds arrive[i] for the whole scan, port B streams entry j
  assign cmp_req.mode    = mode_q;
  assign cmp_req.t       = rd_a.arrive;
  assign cmp_req.ent     = rd_b;
  assign cmp_req.cur_end = end_q;

  pio_cmp u_cmp (
    .req_i (cmp_req),
    .rsp_o (cmp_rsp)
  );

  assign issue      = (state_q == ST_SCAN) && (j_q != n_q);
  assign cnt_fin    = acc_q + CW'(cmp_rsp.flag);
  assign end_fin    = cmp_rsp.flag ? rd_b.depart : end_q;
  assign count_done = (state_q == ST_SCAN) && rv_q && rl_q && (mode_q == CMP_COUNT);
  assign i_is_last  = (CW'(i_q) == n_q - CW'(1));

  // per-arrival overlap counts, kept for the period pass
  always_ff @(posedge clk_i) begin
    if (count_done) begin
      cnt_mem[i_q] <= cnt_fin;
    end
    cnt_rd_q <= cnt_mem[i_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      mode_q     <= CMP_COUNT;
      n_q        <= '0;
      ovf_q      <= 1'b0;
      best_q     <= '0;
      last_idx_q <= '0;
      i_q        <= '0;
      j_q        <= '0;
      rv_q       <= 1'b0;
      rl_q       <= 1'b0;
      acc_q      <= '0;
      end_q      <= '0;
      strobe_q   <= 1'b0;
      res_q      <= '0;
    end else begin
      strobe_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (n_q != FULL) begin
              n_q <= n_q + CW'(1);
            end else begin
              ovf_q <= 1'b1;   // store full, word dropped
            end
            if (item_i.last_flight) begin
              state_q    <= ST_SCAN;
              mode_q     <= CMP_COUNT;
              i_q        <= '0;
              j_q        <= '0;
              acc_q      <= '0;
              rv_q       <= 1'b0;
              last_idx_q <= '0;
            end
          end
        end

        ST_SCAN: begin
          if (issue) begin
            j_q  <= j_q + CW'(1);
            rv_q <= 1'b1;
            rl_q <= (j_q == n_q - CW'(1));
          end else begin
            rv_q <= 1'b0;
          end
          if (rv_q) begin
            if (mode_q == CMP_COUNT) begin
              if (rl_q) begin
                // a higher count restarts the period list, an equal one extends it
                if (cnt_fin > best_q) begin
                  best_q     <= cnt_fin;
                  last_idx_q <= i_q;
                end else if (cnt_fin == best_q) begin
                  last_idx_q <= i_q;
                end
                if (i_is_last) begin
                  state_q <= ST_PEAK;
                end else begin
                  i_q   <= i_q + AW'(1);
                  j_q   <= '0;
                  acc_q <= '0;
                end
              end else begin
                acc_q <= cnt_fin;
              end
            end else begin
              if (rl_q) begin
                strobe_q           <= 1'b1;
                res_q.kind         <= KIND_PERIOD;
                res_q.peak_count   <= PEAK_W'(best_q);
                res_q.period_start <= rd_a.arrive;
                res_q.period_end   <= end_fin;
                res_q.overflow     <= ovf_q;
                res_q.last_result  <= (i_q == last_idx_q);
                if (i_q == last_idx_q) begin
                  state_q <= ST_IDLE;
                  n_q     <= '0;
                  ovf_q   <= 1'b0;
                  best_q  <= '0;
                end else begin
                  i_q     <= i_q + AW'(1);
                  state_q <= ST_PWAIT;
                end
              end else begin
                end_q <= end_fin;
              end
            end
          end
        end

        ST_PEAK: begin
          strobe_q           <= 1'b1;
          res_q.kind         <= KIND_PEAK;
          res_q.peak_count   <= PEAK_W'(best_q);
          res_q.period_start <= '0;
          res_q.period_end   <= '0;
          res_q.overflow     <= ovf_q;
          // at least one interval is always stored, so a period always follows
          res_q.last_result  <= 1'b0;
          i_q                <= '0;
          state_q            <= ST_PWAIT;
        end

        ST_PWAIT: begin
          state_q <= ST_PCHK;
        end

        ST_PCHK: begin
          if (cnt_rd_q == best_q) begin
            mode_q  <= CMP_END;
            end_q   <= END_CAP;
            j_q     <= '0;
            rv_q    <= 1'b0;
            state_q <= ST_SCAN;
          end else begin
            i_q     <= i_q + AW'(1);
            state_q <= ST_PWAIT;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign result_strobe_o = strobe_q;
  assign result_o        = res_q;

  `PIO_ASSERT(a_strobe_after_busy, result_strobe_o |-> $past(busy), "result without a run")
  `PIO_ASSERT(a_last_ends_run, (result_strobe_o && result_o.last_result) |-> !busy,
              "run did not end on final result")
  `PIO_ASSERT_INV(a_best_bounded, best_q <= n_q, "peak above stored count")
  `PIO_ASSERT_INV(a_scan_bounded, (state_q != ST_SCAN) || (j_q <= n_q),
                  "scan index past stored count")

endmodule

/* verif/tb_peak_interval_overlap_finder.sv */
// Testbench for peak_interval_overlap_finder: interval sets in, peak and busiest periods checked
`timescale 1ns / 100ps

module tb_peak_interval_overlap_finder import pio_pkg::*; ();

  // Keeps the intervals of the set being loaded and, when the closing word is
  // taken, computes the peak count and busiest periods the block should report.
  class busy_period_book;
    logic [TIME_W-1:0] arrive_q[MAX_INTERVALS_DEF];
    logic [TIME_W-1:0] depart_q[MAX_INTERVALS_DEF];
    int unsigned       stored;
    bit                dropped;
    res_word_t         pending_results[$];
    int unsigned       errors;

    function void load_interval(in_word_t w);
      int unsigned       best;
      int unsigned       cnt;
      logic [TIME_W-1:0] t;
      logic [TIME_W-1:0] end_t;
      logic [TIME_W-1:0] starts[$];
      logic [TIME_W-1:0] ends[$];
      res_word_t         r;
      if (stored < MAX_INTERVALS_DEF) begin
        arrive_q[stored] = w.arrive_time;
        depart_q[stored] = w.depart_time;
        stored++;
      end else begin
        dropped = 1'b1;
      end
      if (!w.last_flight) return;

      best = 0;
      for (int i = 0; i < stored; i++) begin
        t   = arrive_q[i];
        cnt = 0;
        for (int j = 0; j < stored; j++)
          if (arrive_q[j] <= t && t <= depart_q[j]) cnt++;
        if (cnt > best) begin
          best = cnt;
          starts.delete();
          ends.delete();
        end
        if (cnt == best) begin
          // earliest departure strictly after t, never above the cap
          end_t = END_CAP;
          for (int j = 0; j < stored; j++)
            if (depart_q[j] > t && depart_q[j] < end_t) end_t = depart_q[j];
          starts.push_back(t);
          ends.push_back(end_t);
        end
      end

      r = '{kind: KIND_PEAK, peak_count: PEAK_W'(best), period_start: '0, period_end: '0,
            overflow: dropped, last_result: (starts.size() == 0)};
      pending_results.push_back(r);
      for (int p = 0; p < starts.size(); p++) begin
        r = '{kind: KIND_PERIOD, peak_count: PEAK_W'(best), period_start: starts[p],
              period_end: ends[p], overflow: dropped, last_result: (p == starts.size() - 1)};
        pending_results.push_back(r);
      end
      stored  = 0;
      dropped = 1'b0;
    endfunction

    function void check_field(string name, logic [TIME_W-1:0] exp_v,
                              logic [TIME_W-1:0] got_v);
      if (got_v !== exp_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void match_result(res_word_t got);
      res_word_t exp_r;
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: %p", got);
        errors++;
        return;
      end
      exp_r = pending_results.pop_front();
      check_field("kind",         TIME_W'(exp_r.kind),       TIME_W'(got.kind));
      check_field("peak_count",   TIME_W'(exp_r.peak_count), TIME_W'(got.peak_count));
      check_field("period_start", exp_r.period_start,        got.period_start);
      check_field("period_end",   exp_r.period_end,          got.period_end);
      check_field("overflow",     TIME_W'(exp_r.overflow),   TIME_W'(got.overflow));
      check_field("last_result",  TIME_W'(exp_r.last_result), TIME_W'(got.last_result));
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction
  endclass

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned ITEM_TARGET  = 350;
  // idle time after the last expected result word has been checked
  localparam int unsigned TAIL_CYCLES  = 600;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  in_word_t  item_i;
  logic      result_strobe_o;
  res_word_t result_o;

  busy_period_book book;
  int unsigned     cycles = 0;
  int unsigned     items_sent;

  peak_interval_overlap_finder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_strobe_o(result_strobe_o),
    .result_o       (result_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Results cannot be stalled; every strobed word is checked at the edge that ends it.
  always @(posedge clk_i) begin
    if (rst_ni && result_strobe_o) book.match_result(result_o);
  end

  function automatic in_word_t mk_word(int unsigned a, int unsigned d, bit last);
    return '{arrive_time: TIME_W'(a), depart_time: TIME_W'(d), last_flight: last};
  endfunction

  // Idle for a random number of cycles (junk on the item bus while start is low),
  // then offer the word until the block takes it.
  task automatic send_word(in_word_t w, int unsigned gap_max);
    int unsigned gap;
    gap = $urandom_range(0, gap_max);
    repeat (gap) begin
      @(negedge clk_i);
      start  = 1'b0;
      item_i = mk_word($urandom_range(0, 4095), $urandom_range(0, 4095),
                       1'($urandom_range(0, 1)));
    end
    @(negedge clk_i);
    start  = 1'b1;
    item_i = w;
    do @(posedge clk_i); while (busy);
    book.load_interval(w);
    items_sent++;
  endtask

  // Mostly clock-like HHMM values drawn from a coarse grid so that counts tie;
  // now and then an extreme or an arbitrary 12-bit value.
  function automatic int unsigned rand_time();
    case ($urandom_range(0, 9))
      0:       return ($urandom_range(0, 1) != 0) ? 0 : (($urandom_range(0, 1) != 0) ? 2400 : 4095);
      1:       return $urandom_range(0, 4095);
      2:       return $urandom_range(0, 23) * 100 + $urandom_range(0, 59);
      default: return $urandom_range(6, 20) * 100 + $urandom_range(0, 3) * 15;
    endcase
  endfunction

  task automatic run_random_set(int unsigned n, int unsigned gap_max);
    int unsigned a;
    int unsigned d;
    for (int unsigned k = 0; k < n; k++) begin
      a = rand_time();
      if ($urandom_range(0, 9) == 0) begin
        d = rand_time();  // may come out reversed
      end else begin
        d = a + $urandom_range(0, 4) * 45 + $urandom_range(0, 30);
        if (a <= 2400 && d > 2400) d = 2400;
        if (d > 4095) d = 4095;
      end
      send_word(mk_word(a, d, k == n - 1), gap_max);
    end
  endtask

  initial begin
    int unsigned gap_max;
    int unsigned set_len;
    book       = new();
    items_sent = 0;
    start      = 1'b0;
    item_i     = '0;
    rst_ni     = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed sets.
    // whole day in one interval
    send_word(mk_word(0, 2400, 1'b1), 14);
    // reversed and out of range: count of zero still yields a period, end stays capped
    send_word(mk_word(4095, 0, 1'b1), 14);
    // tie on a repeated arrival after the best is raised
    send_word(mk_word(800, 1000, 1'b0), 0);
    send_word(mk_word(900, 1100, 1'b0), 0);
    send_word(mk_word(900, 1200, 1'b1), 0);
    // reversed interval first, then a real one clears the zero-count period
    send_word(mk_word(1500, 1000, 1'b0), 3);
    send_word(mk_word(1100, 1400, 1'b1), 3);
    // no later departure than the arrival
    send_word(mk_word(2359, 2359, 1'b1), 0);
    // store full: 16 identical intervals give peak 16; the 17th is dropped but closes the set
    for (int k = 0; k < 17; k++) send_word(mk_word(0, 2359, k == 16), (k < 8) ? 0 : 14);

    // Random sets: mostly short, some filling or overflowing the store.
    while (items_sent < ITEM_TARGET) begin
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
      case ($urandom_range(0, 9))
        0:       set_len = $urandom_range(16, 20);
        1:       set_len = 1;
        default: set_len = $urandom_range(2, 8);
      endcase
      run_random_set(set_len, gap_max);
    end
    @(negedge clk_i);
    start = 1'b0;

    while (book.outstanding() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (book.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
